// ===== rtl/ftm_pkg.sv =====
`timescale 1ns / 1ps

package ftm_pkg;

    // Design constants
    localparam int NUM_OUTPUTS = 4;
    localparam int TIME_WIDTH  = 40;
    localparam int SAMPLE_W    = 24;
    localparam int COUNT_W     = 16;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int ERR_W       = 2;

    // Stream payload widths, rounded up to whole bytes
    localparam int IN_FIELDS_W  = TIME_WIDTH + 2 * NUM_OUTPUTS * SAMPLE_W + 1;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ERR_W + 1 + COUNT_W + 2 * SAMPLE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Register reset values
    localparam logic [CFG_W-1:0] SPREAD_LIMIT_RST = CFG_W'(1000);
    localparam logic [CFG_W-1:0] FRAME_LIMIT_RST  = CFG_W'(50000);
    localparam logic [CFG_W-1:0] WINDOW_TICKS_RST = CFG_W'(1000000);
    localparam logic [CFG_W-1:0] HOLD_TICKS_RST   = CFG_W'(500000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPREAD_LIMIT = 2'd0,
        CFG_FRAME_LIMIT  = 2'd1,
        CFG_WINDOW_TICKS = 2'd2,
        CFG_HOLD_TICKS   = 2'd3
    } t_cfg_index;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_SPREAD   = 2'd2,
        ERR_FRAME    = 2'd3
    } t_err_code;

    typedef enum logic [0:0] {
        MODE_START    = 1'b0,
        MODE_COMPLETE = 1'b1
    } t_mode;

    typedef struct packed {
        logic [CFG_W-1:0] spread_limit;
        logic [CFG_W-1:0] frame_limit;
        logic [CFG_W-1:0] window_ticks;
        logic [CFG_W-1:0] hold_ticks;
    } t_cfg;

    typedef struct packed {
        t_mode                 mode;
        logic [TIME_WIDTH-1:0] time_now;
        logic                  overflow;
    } t_meta;

    typedef struct packed {
        logic [SAMPLE_W-1:0] spread;
        logic [SAMPLE_W-1:0] longest;
        logic                frame_over;
    } t_stats;

    typedef struct packed {
        t_err_code           error_code;
        logic                permanent;
        logic [COUNT_W-1:0]  frames;
        logic [SAMPLE_W-1:0] spread;
        logic [SAMPLE_W-1:0] longest;
    } t_result;

endpackage

// ===== rtl/ftm_lane.sv =====
`timescale 1ns / 1ps

// One output's samples: registers them and flags a frame time over the limit.
module ftm_lane (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [ftm_pkg::SAMPLE_W-1:0] i_render,
    input  logic [ftm_pkg::SAMPLE_W-1:0] i_frame,
    input  logic [ftm_pkg::CFG_W-1:0]    i_frame_limit,
    output logic [ftm_pkg::SAMPLE_W-1:0] o_render,
    output logic [ftm_pkg::SAMPLE_W-1:0] o_frame,
    output logic                         o_frame_over
);

    logic [ftm_pkg::SAMPLE_W-1:0] r_render;
    logic [ftm_pkg::SAMPLE_W-1:0] r_frame;
    logic                         r_frame_over;

    // Capture the sample and compare against the limit in the same step.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_render     <= i_render;
            r_frame      <= i_frame;
            r_frame_over <= (i_frame > i_frame_limit);
        end
    end

    assign o_render     = r_render;
    assign o_frame      = r_frame;
    assign o_frame_over = r_frame_over;

endmodule

// ===== rtl/ftm_merge.sv =====
`timescale 1ns / 1ps

// Combines the lanes: render spread, longest frame and any frame over limit.
module ftm_merge (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [ftm_pkg::SAMPLE_W-1:0] i_render [ftm_pkg::NUM_OUTPUTS],
    input  logic [ftm_pkg::SAMPLE_W-1:0] i_frame  [ftm_pkg::NUM_OUTPUTS],
    input  logic [ftm_pkg::NUM_OUTPUTS-1:0] i_frame_over,
    output ftm_pkg::t_stats              o_stats
);

    ftm_pkg::t_stats r_stats;
    ftm_pkg::t_stats n_stats;

    // Minimum and maximum over the lanes.
    always_comb begin
        logic [ftm_pkg::SAMPLE_W-1:0] lo;
        logic [ftm_pkg::SAMPLE_W-1:0] hi;
        logic [ftm_pkg::SAMPLE_W-1:0] longest;
        lo      = i_render[0];
        hi      = i_render[0];
        longest = '0;
        for (int i = 0; i < ftm_pkg::NUM_OUTPUTS; i++) begin
            if (i_render[i] < lo) lo = i_render[i];
            if (i_render[i] > hi) hi = i_render[i];
            if (i_frame[i] > longest) longest = i_frame[i];
        end
        n_stats.spread     = hi - lo;
        n_stats.longest    = longest;
        n_stats.frame_over = |i_frame_over;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stats <= n_stats;
        end
    end

    assign o_stats = r_stats;

endmodule

// ===== rtl/ftm_state.sv =====
`timescale 1ns / 1ps

// Error, window and display state; its registers also form the result.
module ftm_state (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  ftm_pkg::t_meta   i_meta,
    input  ftm_pkg::t_stats  i_stats,
    input  ftm_pkg::t_cfg    i_cfg,
    output ftm_pkg::t_result o_result
);

    localparam int TW = ftm_pkg::TIME_WIDTH;
    localparam int SW = ftm_pkg::SAMPLE_W;
    localparam int CW = ftm_pkg::COUNT_W;

    ftm_pkg::t_err_code r_err, n_err;
    logic               r_locked, n_locked;
    logic [TW-1:0]      r_err_time, n_err_time;
    logic [SW-1:0]      r_win_spread, n_win_spread;
    logic [SW-1:0]      r_disp_spread, n_disp_spread;
    logic [SW-1:0]      r_win_frame, n_win_frame;
    logic [SW-1:0]      r_disp_frame, n_disp_frame;
    logic [CW-1:0]      r_frame_count, n_frame_count;
    logic [CW-1:0]      r_disp_frames, n_disp_frames;
    logic [TW-1:0]      r_elapsed, n_elapsed;
    logic [TW-1:0]      r_prev_time, n_prev_time;

    logic [TW-1:0] delta;
    logic [TW:0]   sum;
    logic [TW-1:0] elapsed_sat;
    logic [TW:0]   remain;
    logic          window_done;
    logic [TW-1:0] since_err;
    logic          hold_over;
    logic          spread_over;
    logic [SW-1:0] max_spread;
    logic [SW-1:0] max_frame;

    // Window accounting: saturating add, then subtract the window length.
    assign delta       = i_meta.time_now - r_prev_time;
    assign sum         = {1'b0, r_elapsed} + {1'b0, delta};
    assign elapsed_sat = sum[TW] ? '1 : sum[TW-1:0];
    assign remain      = {1'b0, elapsed_sat} - {{(TW + 1 - ftm_pkg::CFG_W){1'b0}},
                                                i_cfg.window_ticks};
    assign window_done = !remain[TW];

    // Hold timer for a non-permanent error.
    assign since_err = i_meta.time_now - r_err_time;
    assign hold_over = since_err > {{(TW - ftm_pkg::CFG_W){1'b0}}, i_cfg.hold_ticks};

    // Limits and running window maxima.
    assign spread_over = i_stats.spread > i_cfg.spread_limit;
    assign max_spread  = (i_stats.spread > r_win_spread) ? i_stats.spread : r_win_spread;
    assign max_frame   = (i_stats.longest > r_win_frame) ? i_stats.longest : r_win_frame;

    // Next state for one item.
    always_comb begin
        n_err         = r_err;
        n_locked      = r_locked;
        n_err_time    = r_err_time;
        n_win_spread  = r_win_spread;
        n_disp_spread = r_disp_spread;
        n_win_frame   = r_win_frame;
        n_disp_frame  = r_disp_frame;
        n_frame_count = r_frame_count;
        n_disp_frames = r_disp_frames;
        n_elapsed     = r_elapsed;
        n_prev_time   = r_prev_time;
        if (i_take) begin
            unique case (i_meta.mode)
                ftm_pkg::MODE_START: begin
                    n_win_spread = max_spread;
                    n_win_frame  = max_frame;
                    n_elapsed    = elapsed_sat;
                    n_prev_time  = i_meta.time_now;
                    if (window_done) begin
                        n_disp_frames = r_frame_count;
                        n_frame_count = '0;
                        n_elapsed     = remain[TW-1:0];
                        n_disp_spread = max_spread;
                        n_win_spread  = '0;
                        n_disp_frame  = max_frame;
                        n_win_frame   = '0;
                    end
                    // A fresh report restarts the hold, so it cannot clear at once.
                    if (!r_locked) begin
                        if (i_stats.frame_over) begin
                            n_err      = ftm_pkg::ERR_FRAME;
                            n_err_time = i_meta.time_now;
                        end else if (spread_over) begin
                            n_err      = ftm_pkg::ERR_SPREAD;
                            n_err_time = i_meta.time_now;
                        end else if (hold_over) begin
                            n_err = ftm_pkg::ERR_NONE;
                        end
                    end
                end
                ftm_pkg::MODE_COMPLETE: begin
                    if (r_frame_count != '1) begin
                        n_frame_count = r_frame_count + CW'(1);
                    end
                    if (i_meta.overflow && !r_locked) begin
                        n_err      = ftm_pkg::ERR_OVERFLOW;
                        n_locked   = 1'b1;
                        n_err_time = i_meta.time_now;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err         <= ftm_pkg::ERR_NONE;
            r_locked      <= 1'b0;
            r_err_time    <= '0;
            r_win_spread  <= '0;
            r_disp_spread <= '0;
            r_win_frame   <= '0;
            r_disp_frame  <= '0;
            r_frame_count <= '0;
            r_disp_frames <= '0;
            r_elapsed     <= '0;
            r_prev_time   <= '0;
        end else begin
            r_err         <= n_err;
            r_locked      <= n_locked;
            r_err_time    <= n_err_time;
            r_win_spread  <= n_win_spread;
            r_disp_spread <= n_disp_spread;
            r_win_frame   <= n_win_frame;
            r_disp_frame  <= n_disp_frame;
            r_frame_count <= n_frame_count;
            r_disp_frames <= n_disp_frames;
            r_elapsed     <= n_elapsed;
            r_prev_time   <= n_prev_time;
        end
    end

    assign o_result.error_code = r_err;
    assign o_result.permanent  = r_locked;
    assign o_result.frames     = r_disp_frames;
    assign o_result.spread     = r_disp_spread;
    assign o_result.longest    = r_disp_frame;

endmodule

// ===== rtl/frame_timing_monitor.sv =====
`timescale 1ns / 1ps
// Pipeline: a result is offered once its input transfer has passed the lane,
// merge and state registers, and it transfers when the output is ready.
// Throughput: one item per cycle while the output is not stalled; the stages
// advance independently, so bubbles close up while a result waits at the output.
// Reset: synchronous, active low; clears the pipeline valid flags and all
// state registers, and restores the register defaults.

module frame_timing_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration writes
    input  logic                            i_cfg_we,
    input  logic [ftm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ftm_pkg::CFG_W-1:0]       i_cfg_data,
    // Input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: time_now, render_time_0..3, frame_time_0..3, counter_overflow, zero pad
    input  logic [ftm_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: mode
    input  logic [0:0]                      i_s_axis_tuser,
    // Output stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: error_code, error_is_permanent, frames_per_window, shown_spread,
    // shown_longest_frame, zero pad
    output logic [ftm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int NO = ftm_pkg::NUM_OUTPUTS;
    localparam int SW = ftm_pkg::SAMPLE_W;
    localparam int TW = ftm_pkg::TIME_WIDTH;

    ftm_pkg::t_cfg    r_cfg;
    ftm_pkg::t_meta   r_a_meta;
    ftm_pkg::t_meta   r_b_meta;
    ftm_pkg::t_meta   in_meta;
    ftm_pkg::t_stats  stats;
    ftm_pkg::t_result result;
    logic             r_a_valid;
    logic             r_b_valid;
    logic             r_c_valid;
    logic             en_a;
    logic             en_b;
    logic             en_c;

    logic [SW-1:0] lane_render [NO];
    logic [SW-1:0] lane_frame  [NO];
    logic [NO-1:0] lane_over;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spread_limit <= ftm_pkg::SPREAD_LIMIT_RST;
            r_cfg.frame_limit  <= ftm_pkg::FRAME_LIMIT_RST;
            r_cfg.window_ticks <= ftm_pkg::WINDOW_TICKS_RST;
            r_cfg.hold_ticks   <= ftm_pkg::HOLD_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (ftm_pkg::t_cfg_index'(i_cfg_index))
                ftm_pkg::CFG_SPREAD_LIMIT: r_cfg.spread_limit <= i_cfg_data;
                ftm_pkg::CFG_FRAME_LIMIT:  r_cfg.frame_limit  <= i_cfg_data;
                ftm_pkg::CFG_WINDOW_TICKS: r_cfg.window_ticks <= i_cfg_data;
                ftm_pkg::CFG_HOLD_TICKS:   r_cfg.hold_ticks   <= i_cfg_data;
            endcase
        end
    end

    // Stage enables: a stage moves when it is empty or the next one moves.
    assign en_c            = !r_c_valid || i_m_axis_tready;
    assign en_b            = !r_b_valid || en_c;
    assign en_a            = !r_a_valid || en_b;
    assign o_s_axis_tready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (en_a) r_a_valid <= i_s_axis_tvalid;
            if (en_b) r_b_valid <= r_a_valid;
            if (en_c) r_c_valid <= r_b_valid;
        end
    end

    // Item kind, time stamp and overflow flag travel alongside the lanes.
    assign in_meta.mode     = ftm_pkg::t_mode'(i_s_axis_tuser[0]);
    assign in_meta.time_now = i_s_axis_tdata[TW-1:0];
    assign in_meta.overflow = i_s_axis_tdata[TW + 2 * NO * SW];

    always_ff @(posedge i_clk) begin
        if (en_a) r_a_meta <= in_meta;
        if (en_b) r_b_meta <= r_a_meta;
    end

    // One lane per display output.
    for (genvar g = 0; g < NO; g++) begin : g_lane
        ftm_lane u_lane (
            .i_clk        (i_clk),
            .i_en         (en_a),
            .i_render     (i_s_axis_tdata[TW + g * SW +: SW]),
            .i_frame      (i_s_axis_tdata[TW + (NO + g) * SW +: SW]),
            .i_frame_limit(r_cfg.frame_limit),
            .o_render     (lane_render[g]),
            .o_frame      (lane_frame[g]),
            .o_frame_over (lane_over[g])
        );
    end

    ftm_merge u_merge (
        .i_clk       (i_clk),
        .i_en        (en_b),
        .i_render    (lane_render),
        .i_frame     (lane_frame),
        .i_frame_over(lane_over),
        .o_stats     (stats)
    );

    ftm_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (r_b_valid && en_c),
        .i_meta  (r_b_meta),
        .i_stats (stats),
        .i_cfg   (r_cfg),
        .o_result(result)
    );

    // Result transfer; the state registers hold still while it waits.
    assign o_m_axis_tvalid = r_c_valid;
    assign o_m_axis_tdata  = {{(ftm_pkg::OUT_TDATA_W - ftm_pkg::OUT_FIELDS_W){1'b0}},
                              result.longest, result.spread, result.frames,
                              result.permanent, result.error_code};

endmodule

// ===== rtl/ftm_checker.sv =====
`timescale 1ns / 1ps

module ftm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [ftm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its data.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result data changed while stalled");

    // With no result waiting, the input side is always open.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with an empty output");

    // A permanent error stays until reset.
    a_perm_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tdata[2] |=> o_m_axis_tdata[2])
        else $error("permanent error released");

    // Only a counter overflow can be permanent.
    a_perm_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tdata[2] |-> o_m_axis_tdata[1:0] == ftm_pkg::ERR_OVERFLOW)
        else $error("permanent error with wrong code");

endmodule

bind frame_timing_monitor ftm_checker u_ftm_checker (.*);
